### src/fcl_pkg.sv
package fcl_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned FINGERS      = 6;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned DIFF_W       = 17;
  localparam int unsigned MUL_W        = 18;
  localparam int unsigned PROD_W       = 2 * MUL_W;
  localparam int unsigned ACC_W        = 35;
  localparam int unsigned ROT_W        = ACC_W + 18;
  localparam int unsigned ANG_W        = 26;
  localparam int unsigned NUM_W        = 31;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [15:0] ANGLE_MAX    = 16'd46080;
  localparam logic [15:0] SMOOTH_RESET = 16'd45875;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LAST  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_PRE, ST_CORDIC, ST_RND, ST_DIV,
    ST_SQ, ST_EMA0, ST_EMA1, ST_CURL, ST_JOINT, ST_DONE
  } fcl_state_e;

  typedef struct packed {
    logic             accept;
    fcl_state_e       st;
    logic [CNT_W-1:0] cnt;
  } fcl_cmd_t;

  typedef struct packed {
    logic deg;
    logic out_free;
  } fcl_status_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_deg(input logic [CNT_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // finger degree ranges in Q8.8
  function automatic logic [15:0] range_lo(input logic [2:0] f);
    logic [15:0] v;
    unique case (f)
      3'd0: v = 16'd6400;
      3'd1: v = 16'd28160;
      3'd5: v = 16'd23040;
      default: v = 16'd17920;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] range_hi(input logic [2:0] f);
    return (f == 3'd0) ? 16'd12800 : 16'd43520;
  endfunction

  function automatic logic [14:0] limit_reset(input int unsigned f);
    logic [14:0] v;
    if (f == 0) v = 15'd21430;
    else if (f == 1) v = 15'd9830;
    else v = 15'd24084;
    return v;
  endfunction

endpackage

### src/fcl_if.sv
interface fcl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  finger;
  logic signed [15:0] tip_x;
  logic signed [15:0] tip_y;
  logic signed [15:0] mid_x;
  logic signed [15:0] mid_y;
  logic signed [15:0] base_x;
  logic signed [15:0] base_y;
  modport source (output valid, finger, tip_x, tip_y, mid_x, mid_y, base_x, base_y,
                  input ready);
  modport sink (input valid, finger, tip_x, tip_y, mid_x, mid_y, base_x, base_y,
                output ready);
endinterface

interface fcl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  finger_out;
  logic [15:0] curl;
  logic [15:0] angle;
  logic [14:0] joint_position;
  logic        degenerate;
  modport source (output valid, finger_out, curl, angle, joint_position, degenerate,
                  input ready);
  modport sink (input valid, finger_out, curl, angle, joint_position, degenerate,
                output ready);
endinterface

interface fcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/fcl_ctrl.sv
module fcl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fcl_pkg::fcl_status_t status_i,
  output fcl_pkg::fcl_cmd_t   cmd_o
);

  fcl_pkg::fcl_state_e state_q, state_d;
  logic [fcl_pkg::CNT_W-1:0] cnt_q, cnt_d;

  localparam logic [fcl_pkg::CNT_W-1:0] CordicLast = fcl_pkg::CNT_W'(fcl_pkg::CORDIC_STEPS - 1);
  localparam logic [fcl_pkg::CNT_W-1:0] DivFirst   = fcl_pkg::CNT_W'(fcl_pkg::NUM_W - 1);
  localparam logic [fcl_pkg::CNT_W-1:0] MulLast    = fcl_pkg::CNT_W'(3);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      fcl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fcl_pkg::ST_MUL;
          cnt_d   = '0;
        end
      end
      fcl_pkg::ST_MUL: begin
        if (status_i.deg) state_d = fcl_pkg::ST_DONE;
        else if (cnt_q == MulLast) state_d = fcl_pkg::ST_PRE;
        else cnt_d = cnt_q + 1'b1;
      end
      fcl_pkg::ST_PRE: begin
        state_d = fcl_pkg::ST_CORDIC;
        cnt_d   = '0;
      end
      fcl_pkg::ST_CORDIC: begin
        if (cnt_q == CordicLast) state_d = fcl_pkg::ST_RND;
        else cnt_d = cnt_q + 1'b1;
      end
      fcl_pkg::ST_RND: begin
        state_d = fcl_pkg::ST_DIV;
        cnt_d   = DivFirst;
      end
      fcl_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = fcl_pkg::ST_SQ;
        else cnt_d = cnt_q - 1'b1;
      end
      fcl_pkg::ST_SQ:    state_d = fcl_pkg::ST_EMA0;
      fcl_pkg::ST_EMA0:  state_d = fcl_pkg::ST_EMA1;
      fcl_pkg::ST_EMA1:  state_d = fcl_pkg::ST_CURL;
      fcl_pkg::ST_CURL:  state_d = fcl_pkg::ST_JOINT;
      fcl_pkg::ST_JOINT: state_d = fcl_pkg::ST_DONE;
      fcl_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = fcl_pkg::ST_IDLE;
      end
      default: state_d = fcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == fcl_pkg::ST_IDLE);
    cmd_o.accept  = in_ready_o && in_valid_i;
    cmd_o.st      = state_q;
    cmd_o.cnt     = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcl_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### src/fcl_dp.sv
module fcl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fcl_in_if.sink               in_i,
  fcl_out_if.source            out_o,
  fcl_cfg_if.sink              cfg_i,
  input  fcl_pkg::fcl_cmd_t    cmd_i,
  output fcl_pkg::fcl_status_t status_o
);

  localparam int unsigned DW = fcl_pkg::DIFF_W;
  localparam int unsigned MW = fcl_pkg::MUL_W;
  localparam int unsigned PW = fcl_pkg::PROD_W;
  localparam int unsigned AW = fcl_pkg::ACC_W;
  localparam int unsigned RW = fcl_pkg::ROT_W;
  localparam int unsigned ZW = fcl_pkg::ANG_W;

  // configuration and per-finger state
  logic [15:0] smooth_q;
  logic [14:0] limit_q [fcl_pkg::FINGERS];
  logic [15:0] prev_q  [fcl_pkg::FINGERS];
  logic        seen_q  [fcl_pkg::FINGERS];

  // item registers
  logic [2:0]           finger_q;
  logic [2:0]           fidx;
  logic                 deg_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [AW-1:0] dot_q, cross_q, acc_q;
  logic signed [RW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [15:0]          angle_q, span_q;
  logic [fcl_pkg::NUM_W-1:0] numer_q;
  logic [14:0]          rem_q;
  logic [16:0]          quo_q;
  logic [15:0]          raw_q, curl_q;
  logic [14:0]          joint_q;

  // output register
  logic        ovalid_q;
  logic [2:0]  ofinger_q;
  logic [15:0] ocurl_q, oangle_q;
  logic [14:0] ojoint_q;
  logic        odeg_q;

  logic signed [DW-1:0] ax_d, ay_d, bx_d, by_d;
  logic                 deg_d;

  function automatic logic near_zero(input logic signed [DW-1:0] v);
    return (v == '0) || (v == DW'(1)) || (v == {DW{1'b1}});
  endfunction

  always_comb begin
    ax_d  = DW'(in_i.tip_x)  - DW'(in_i.mid_x);
    ay_d  = DW'(in_i.tip_y)  - DW'(in_i.mid_y);
    bx_d  = DW'(in_i.base_x) - DW'(in_i.mid_x);
    by_d  = DW'(in_i.base_y) - DW'(in_i.mid_y);
    deg_d = (in_i.finger >= 3'(fcl_pkg::FINGERS))
         || (near_zero(ax_d) && near_zero(ay_d))
         || (near_zero(bx_d) && near_zero(by_d));
  end

  // fingers 6 and 7 never reach the state tables
  assign fidx = (finger_q < 3'(fcl_pkg::FINGERS)) ? finger_q : 3'd0;

  // shared multiplier
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.st)
      fcl_pkg::ST_MUL: begin
        unique case (cmd_i.cnt[1:0])
          2'd0: begin ma = MW'(ax_q); mb = MW'(bx_q); end
          2'd1: begin ma = MW'(ay_q); mb = MW'(by_q); end
          2'd2: begin ma = MW'(ax_q); mb = MW'(by_q); end
          default: begin ma = MW'(ay_q); mb = MW'(bx_q); end
        endcase
      end
      fcl_pkg::ST_SQ: begin
        ma = MW'({1'b0, quo_q});
        mb = MW'({1'b0, quo_q});
      end
      fcl_pkg::ST_EMA0: begin
        ma = MW'({1'b0, smooth_q});
        mb = MW'({1'b0, prev_q[fidx]});
      end
      fcl_pkg::ST_EMA1: begin
        ma = MW'(17'h10000 - {1'b0, smooth_q});
        mb = MW'({1'b0, raw_q});
      end
      fcl_pkg::ST_JOINT: begin
        ma = MW'({1'b0, limit_q[fidx]});
        mb = MW'({1'b0, curl_q});
      end
      default: ;
    endcase
    prod = ma * mb;
  end

  // cordic micro-rotation
  logic signed [RW-1:0] xs, ys, x_it, y_it;
  logic signed [ZW-1:0] z_it;
  logic signed [ZW-1:0] atan_s;
  always_comb begin
    xs     = x_q >>> cmd_i.cnt;
    ys     = y_q >>> cmd_i.cnt;
    atan_s = ZW'(fcl_pkg::atan_deg(cmd_i.cnt));
    x_it   = x_q;
    y_it   = y_q;
    z_it   = z_q;
    if (y_q > 0) begin
      x_it = x_q + ys;
      y_it = y_q - xs;
      z_it = z_q + atan_s;
    end else if (y_q < 0) begin
      x_it = x_q - ys;
      y_it = y_q + xs;
      z_it = z_q - atan_s;
    end
  end

  // rounding, clamp and divider numerator
  logic signed [ZW-1:0] z_rnd;
  logic [15:0] angle_d, lo, hi, span, clamped;
  always_comb begin
    z_rnd = (z_q + ZW'(128)) >>> 8;
    if (z_rnd < 0) angle_d = '0;
    else if (z_rnd > $signed(ZW'(fcl_pkg::ANGLE_MAX))) angle_d = fcl_pkg::ANGLE_MAX;
    else angle_d = z_rnd[15:0];
    lo   = fcl_pkg::range_lo(finger_q);
    hi   = fcl_pkg::range_hi(finger_q);
    span = hi - lo;
    if (angle_d < lo) clamped = lo;
    else if (angle_d > hi) clamped = hi;
    else clamped = angle_d;
  end

  // restoring divider step
  logic [15:0] trial;
  logic        qbit;
  always_comb begin
    trial = {rem_q, numer_q[cmd_i.cnt]};
    qbit  = (trial >= span_q);
  end

  logic [PW-1:0] prod_rnd;
  logic [PW-1:0] acc_rnd;
  assign prod_rnd = PW'(prod) + PW'(32768);
  assign acc_rnd  = PW'(acc_q) + PW'(32768);

  logic out_load;
  assign out_load = (cmd_i.st == fcl_pkg::ST_DONE) && status_o.out_free;

  always_comb begin
    status_o.deg      = deg_q;
    status_o.out_free = !ovalid_q || out_o.ready;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      finger_q <= in_i.finger;
      deg_q    <= deg_d;
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      bx_q     <= bx_d;
      by_q     <= by_d;
    end
    unique case (cmd_i.st)
      fcl_pkg::ST_MUL: begin
        unique case (cmd_i.cnt[1:0])
          2'd0: dot_q   <= AW'(prod);
          2'd1: dot_q   <= dot_q + AW'(prod);
          2'd2: cross_q <= AW'(prod);
          default: cross_q <= cross_q - AW'(prod);
        endcase
      end
      fcl_pkg::ST_PRE: begin
        if (dot_q < 0) begin
          x_q <= RW'(cross_q < 0 ? -cross_q : cross_q) <<< 16;
          y_q <= -(RW'(dot_q) <<< 16);
          z_q <= ZW'(90 * 65536);
        end else begin
          x_q <= RW'(dot_q) <<< 16;
          y_q <= RW'(cross_q < 0 ? -cross_q : cross_q) <<< 16;
          z_q <= '0;
        end
      end
      fcl_pkg::ST_CORDIC: begin
        x_q <= x_it;
        y_q <= y_it;
        z_q <= z_it;
      end
      fcl_pkg::ST_RND: begin
        angle_q <= angle_d;
        span_q  <= span;
        numer_q <= fcl_pkg::NUM_W'({hi - clamped, 16'd0} + 32'(span >> 1));
        rem_q   <= '0;
        quo_q   <= '0;
      end
      fcl_pkg::ST_DIV: begin
        rem_q <= qbit ? 15'(trial - span_q) : trial[14:0];
        quo_q <= {quo_q[15:0], qbit};
      end
      fcl_pkg::ST_SQ: begin
        raw_q <= (prod_rnd[PW-1:16] > (PW-16)'(16'hFFFF)) ? 16'hFFFF : prod_rnd[31:16];
      end
      fcl_pkg::ST_EMA0: acc_q <= AW'(prod);
      fcl_pkg::ST_EMA1: acc_q <= acc_q + AW'(prod);
      fcl_pkg::ST_CURL: begin
        if (!seen_q[fidx]) curl_q <= raw_q;
        else if (acc_rnd[PW-1:16] > (PW-16)'(16'hFFFF)) curl_q <= 16'hFFFF;
        else curl_q <= acc_rnd[31:16];
      end
      fcl_pkg::ST_JOINT: joint_q <= prod_rnd[30:16];
      default: ;
    endcase
    if (out_load) begin
      ofinger_q <= finger_q;
      odeg_q    <= deg_q;
      ocurl_q   <= deg_q ? '0 : curl_q;
      oangle_q  <= deg_q ? '0 : angle_q;
      ojoint_q  <= deg_q ? '0 : joint_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      smooth_q <= fcl_pkg::SMOOTH_RESET;
      for (int i = 0; i < fcl_pkg::FINGERS; i++) begin
        limit_q[i] <= fcl_pkg::limit_reset(i);
        prev_q[i]  <= '0;
        seen_q[i]  <= 1'b0;
      end
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
      if (out_load && !deg_q) begin
        prev_q[fidx] <= curl_q;
        seen_q[fidx] <= 1'b1;
      end
      if (cfg_i.valid) begin
        if (cfg_i.index == fcl_pkg::REG_SMOOTH) smooth_q <= cfg_i.data;
        else if (cfg_i.index <= fcl_pkg::REG_LIMIT_LAST)
          limit_q[3'(cfg_i.index - fcl_pkg::REG_LIMIT_FIRST)] <= cfg_i.data[14:0];
      end
    end
  end

  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = ovalid_q;
  assign out_o.finger_out     = ofinger_q;
  assign out_o.curl           = ocurl_q;
  assign out_o.angle          = oangle_q;
  assign out_o.joint_position = ojoint_q;
  assign out_o.degenerate     = odeg_q;

endmodule

### src/finger_curl_from_landmarks_top.sv
// finger curl from three 2-d landmarks: one item (finger number, tip, middle
// and base points in q2.14) gives one result with the echoed finger, the
// smoothed curl (q0.16), the joint angle (q8.8 degrees, limited to 0..180),
// the joint position (limit times curl, q1.14) and a degenerate flag. a
// non-degenerate item runs the multiply, cordic, 31-step restoring divider,
// squaring, smoothing, curl and joint steps in turn on one sequencer; a
// degenerate item or unknown finger goes from the first multiply step
// straight to the output. the result sits in an output register, so the
// next item is taken while a result waits. configuration writes are taken
// every cycle and must only happen with the block idle.
module finger_curl_from_landmarks_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcl_in_if.sink    in_i,
  fcl_out_if.source out_o,
  fcl_cfg_if.sink   cfg_i
);

  fcl_pkg::fcl_cmd_t    cmd;
  fcl_pkg::fcl_status_t status;

  // sequencer: one item at a time
  fcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // vectors, shared multiplier, cordic, divider, ema and per-finger state
  fcl_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

### src/fcl_checker.sv
module fcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  finger_out_i,
  input logic [15:0] curl_i,
  input logic [15:0] angle_i,
  input logic [14:0] joint_position_i,
  input logic        degenerate_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(curl_i))
    else $error("result dropped while stalled");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> curl_i == '0 && angle_i == '0 && joint_position_i == '0)
    else $error("degenerate result not zero");

  a_bad_finger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finger_out_i >= 3'(fcl_pkg::FINGERS) |-> degenerate_i)
    else $error("unknown finger not flagged");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> angle_i <= fcl_pkg::ANGLE_MAX)
    else $error("angle out of range");

endmodule

bind finger_curl_from_landmarks_top fcl_checker u_fcl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .finger_out_i     (out_o.finger_out),
  .curl_i           (out_o.curl),
  .angle_i          (out_o.angle),
  .joint_position_i (out_o.joint_position),
  .degenerate_i     (out_o.degenerate)
);
